FILE: design/plcm_pkg.sv
// Package for the piecewise linear curve map: sizes, region codes and the
// stage structs shared by the front, divide and top modules. Depends on nothing.
`default_nettype none
package plcm_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int DIV_STEPS  = 34;

  typedef enum logic [1:0] {
    REG_BELOW  = 2'd0,
    REG_INTERP = 2'd1,
    REG_ABOVE  = 2'd2,
    REG_NONE   = 2'd3
  } region_e;

  typedef struct packed {
    logic        valid;
    region_e     region;
    logic [31:0] q;
  } front_t;

  typedef struct packed {
    logic        valid;
    region_e     region;
    logic        neg;
    logic [33:0] a;
    logic [32:0] b;
    logic [32:0] d;
    logic [32:0] rem;
    logic [33:0] quo;
    logic [31:0] y0;
  } div_t;

endpackage
`default_nettype wire

FILE: design/plcm_ram.sv
// Generic RAM: one write port, two registered read ports.
// Depends on nothing.
`default_nettype none
module plcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

FILE: design/plcm_front.sv
// Front stage: breakpoint storage, segment search and breakpoint fetch.
// Depends on plcm_pkg and plcm_ram.
`default_nettype none
module plcm_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     req_i,
  input  wire logic                     kind_i,
  input  wire logic [3:0]               point_index_i,
  input  wire logic [31:0]              point_x_i,
  input  wire logic [31:0]              point_y_i,
  input  wire logic [31:0]              query_x_i,
  input  wire logic [4:0]               point_count_i,
  output plcm_pkg::front_t              front_o,
  output logic      [31:0]              x0_o,
  output logic      [31:0]              x1_o,
  output logic      [31:0]              y0_o,
  output logic      [31:0]              y1_o
);

  logic [31:0] xtab_q [plcm_pkg::MAX_POINTS];
  logic [plcm_pkg::MAX_POINTS-1:0] ge;
  logic [4:0] n_used;
  logic [plcm_pkg::IDX_W-1:0] last_idx, seg_idx, seg_nxt, ya_addr, wslot;
  logic seg_found;
  logic load_we;
  plcm_pkg::region_e region_d;
  plcm_pkg::front_t front_q;

  assign load_we = req_i && !kind_i;
  assign wslot   = point_index_i[plcm_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      xtab_q[wslot] <= point_x_i;
    end
  end

  always_comb begin
    if (point_count_i == 5'd0) begin
      n_used = 5'd1;
    end else if (point_count_i > 5'(plcm_pkg::MAX_POINTS)) begin
      n_used = 5'(plcm_pkg::MAX_POINTS);
    end else begin
      n_used = point_count_i;
    end
    last_idx = plcm_pkg::IDX_W'(n_used - 5'd1);
  end

  always_comb begin
    for (int i = 0; i < plcm_pkg::MAX_POINTS; i++) begin
      ge[i] = $signed(query_x_i) >= $signed(xtab_q[i]);
    end
    seg_found = 1'b0;
    seg_idx   = '0;
    for (int i = plcm_pkg::MAX_POINTS - 2; i >= 0; i--) begin
      if ((5'(i) + 5'd1 < n_used) && ge[i] && !ge[i+1]) begin
        seg_found = 1'b1;
        seg_idx   = plcm_pkg::IDX_W'(i);
      end
    end
    seg_nxt = seg_idx + plcm_pkg::IDX_W'(1);
    if (!ge[0]) begin
      region_d = plcm_pkg::REG_BELOW;
      ya_addr  = '0;
    end else if (seg_found) begin
      region_d = plcm_pkg::REG_INTERP;
      ya_addr  = seg_idx;
    end else if (ge[last_idx]) begin
      region_d = plcm_pkg::REG_ABOVE;
      ya_addr  = last_idx;
    end else begin
      region_d = plcm_pkg::REG_NONE;
      ya_addr  = '0;
    end
  end

  plcm_ram #(.WIDTH(32), .DEPTH(plcm_pkg::MAX_POINTS)) u_xram (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   (wslot),
    .wdata_i   (point_x_i),
    .raddr_a_i (seg_idx),
    .raddr_b_i (seg_nxt),
    .rdata_a_o (x0_o),
    .rdata_b_o (x1_o)
  );

  plcm_ram #(.WIDTH(32), .DEPTH(plcm_pkg::MAX_POINTS)) u_yram (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   (wslot),
    .wdata_i   (point_y_i),
    .raddr_a_i (ya_addr),
    .raddr_b_i (seg_nxt),
    .rdata_a_o (y0_o),
    .rdata_b_o (y1_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else begin
      front_q.valid  <= req_i && kind_i;
      front_q.region <= region_d;
      front_q.q      <= query_x_i;
    end
  end

  assign front_o = front_q;

endmodule
`default_nettype wire

FILE: design/plcm_div_stage.sv
// One step of the bit-serial scaled divide floor(a * b / d), registered.
// Depends on plcm_pkg.
`default_nettype none
module plcm_div_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire plcm_pkg::div_t stage_i,
  output plcm_pkg::div_t      stage_o
);

  logic [34:0] t, d1, d2;
  logic [1:0]  digit;
  logic [34:0] rem_w;
  plcm_pkg::div_t nxt;
  plcm_pkg::div_t stage_q;

  always_comb begin
    t  = {1'b0, stage_i.rem, 1'b0} + (stage_i.a[33] ? {2'b00, stage_i.b} : 35'd0);
    d1 = {2'b00, stage_i.d};
    d2 = {1'b0, stage_i.d, 1'b0};
    if (t >= d2) begin
      digit = 2'd2;
      rem_w = t - d2;
    end else if (t >= d1) begin
      digit = 2'd1;
      rem_w = t - d1;
    end else begin
      digit = 2'd0;
      rem_w = t;
    end
    nxt     = stage_i;
    nxt.a   = {stage_i.a[32:0], 1'b0};
    nxt.rem = rem_w[32:0];
    nxt.quo = {stage_i.quo[32:0], 1'b0} + {32'd0, digit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= nxt;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

FILE: design/piecewise_linear_curve_map.sv
// Top level of the piecewise linear curve map: count register, differences,
// divide pipeline and saturating output. Depends on plcm_pkg, plcm_front, plcm_div_stage.
//
// Every cycle takes one request (busy stays low): a load writes one breakpoint
// and gives no result; a query gives one result on valid_o after the front register
// (segment search), the differences register, the 34-step bit-serial divide (one
// step per stage) and the output register. The receiver cannot stall; results
// come out one per cycle in request order. point_count is written through the
// always-ready cfg channel; the user must write it only while idle (not enforced).
`default_nettype none
module piecewise_linear_curve_map (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind_i,
  input  wire logic [3:0]  point_index_i,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] query_x_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,
  output logic             valid_o,
  output logic [31:0]      mapped_y_o,
  output logic [1:0]       region_o
);

  logic [4:0] point_count_q;
  plcm_pkg::front_t front;
  logic [31:0] x0, x1, y0, y1;
  logic [32:0] dq, dx, dy, mag;
  plcm_pkg::div_t s2_q;
  plcm_pkg::div_t pipe [plcm_pkg::DIV_STEPS+1];
  plcm_pkg::div_t last;
  logic [34:0] sum;
  logic [31:0] y_d;
  logic        valid_q;
  logic [31:0] y_q;
  logic [1:0]  region_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 5'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      point_count_q <= cfg_data_i;
    end
  end

  plcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (start && !busy),
    .kind_i        (kind_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .query_x_i     (query_x_i),
    .point_count_i (point_count_q),
    .front_o       (front),
    .x0_o          (x0),
    .x1_o          (x1),
    .y0_o          (y0),
    .y1_o          (y1)
  );

  always_comb begin
    dq  = {front.q[31], front.q} - {x0[31], x0};
    dx  = {x1[31], x1} - {x0[31], x0};
    dy  = {y1[31], y1} - {y0[31], y0};
    mag = dy[32] ? (33'd0 - dy) : dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q.valid  <= front.valid;
      s2_q.region <= front.region;
      s2_q.neg    <= dy[32];
      s2_q.a      <= {1'b0, mag};
      s2_q.b      <= dq;
      s2_q.d      <= dx;
      s2_q.rem    <= '0;
      s2_q.quo    <= '0;
      s2_q.y0     <= y0;
    end
  end

  assign pipe[0] = s2_q;

  for (genvar k = 0; k < plcm_pkg::DIV_STEPS; k++) begin : g_div
    plcm_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (pipe[k]),
      .stage_o (pipe[k+1])
    );
  end

  assign last = pipe[plcm_pkg::DIV_STEPS];

  always_comb begin
    if (last.neg) begin
      sum = {{3{last.y0[31]}}, last.y0} - {1'b0, last.quo};
    end else begin
      sum = {{3{last.y0[31]}}, last.y0} + {1'b0, last.quo};
    end
    case (last.region)
      plcm_pkg::REG_INTERP: begin
        if ($signed(sum) > $signed(35'sh0_7FFF_FFFF)) begin
          y_d = 32'h7FFF_FFFF;
        end else if ($signed(sum) < -$signed(35'sh0_8000_0000)) begin
          y_d = 32'h8000_0000;
        end else begin
          y_d = sum[31:0];
        end
      end
      plcm_pkg::REG_NONE: y_d = '0;
      default: y_d = last.y0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q      <= y_d;
    region_q <= last.region;
  end

  assign valid_o    = valid_q;
  assign mapped_y_o = y_q;
  assign region_o   = region_q;

`ifndef SYNTHESIS
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q.valid && s2_q.region == plcm_pkg::REG_INTERP) |-> (s2_q.b < s2_q.d))
    else $error("interpolation offset not below segment width");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && last.region == plcm_pkg::REG_INTERP) |-> (last.quo <= {1'b0, s2_q.a[32:0]} ||
      last.quo <= 34'h1_FFFF_FFFF))
    else $error("scaled quotient out of range");

  a_out_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid |=> valid_o)
    else $error("result dropped at output stage");
`endif

endmodule
`default_nettype wire
